// File: design/mkslp_pkg.sv
// Shared constants and types for the multi-key short/long press detector.
// Used by every module under design/; depends on nothing else.
package mkslp_pkg;

  localparam int NUM_KEYS        = 8;
  localparam int KEY_W           = $clog2(NUM_KEYS);
  localparam int LEVEL_BITS      = 8;
  localparam int KEY_LIMIT       = (NUM_KEYS < LEVEL_BITS) ? NUM_KEYS : LEVEL_BITS;
  localparam int TIME_BITS       = 48;
  localparam int MIN_PRESS_US    = 30000;
  localparam int DEFAULT_LONG_MS = 800;
  localparam int US_PER_MS       = 1000;
  localparam int LONG_MS_W       = 16;
  localparam int KEY_COUNT_W     = 4;
  localparam int LONG_THR_W      = 26;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS   = 1'd1;

  // Release reports of one poll, handed from the scanner to the report stage.
  typedef struct packed {
    logic                valid;
    logic [NUM_KEYS-1:0] hit;
    logic [NUM_KEYS-1:0] hit_long;
  } rpt_batch_t;

endpackage

// File: design/mkslp_time_ram.sv
// Press-time memory: one entry per key, one write and one read port.
// Read data is registered. Depends on mkslp_pkg.
module mkslp_time_ram
  import mkslp_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [KEY_W-1:0]     waddr,
  input  logic [TIME_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [KEY_W-1:0]     raddr,
  output logic [TIME_BITS-1:0] rdata
);

  logic [TIME_BITS-1:0] mem [NUM_KEYS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/mkslp_scan.sv
// Poll scanner: walks the keys of one poll, updates key_down and the
// press-time memory, and classifies releases. Depends on mkslp_pkg, mkslp_time_ram.
module mkslp_scan
  import mkslp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [LEVEL_BITS-1:0]  in_levels,
  input  logic [TIME_BITS-1:0]   in_now,
  input  logic [KEY_COUNT_W-1:0] key_count,
  input  logic [LONG_MS_W-1:0]   long_press_ms,
  output rpt_batch_t             batch,
  input  logic                   batch_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } scan_state_t;

  scan_state_t           state, state_next;
  logic [LEVEL_BITS-1:0] levels;
  logic [TIME_BITS-1:0]  now;
  logic [LONG_THR_W-1:0] long_thr;
  logic [KEY_W-1:0]      last_idx;
  logic [KEY_W-1:0]      idx;
  logic [NUM_KEYS-1:0]   key_down;
  logic [NUM_KEYS-1:0]   hit;
  logic [NUM_KEYS-1:0]   hit_long;
  logic                  s1_valid;
  logic [KEY_W-1:0]      s1_idx;

  logic                  accept;
  logic                  pressed;
  logic                  do_press;
  logic                  do_release;
  logic [TIME_BITS-1:0]  rdata;
  logic [TIME_BITS-1:0]  hold;
  logic                  is_long;
  logic                  is_short;
  logic [LONG_MS_W-1:0]  lms;
  logic [KEY_W-1:0]      last_idx_in;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // Effective threshold and key range, taken when the poll is accepted.
  always_comb begin
    lms = (long_press_ms == '0) ? LONG_MS_W'(DEFAULT_LONG_MS) : long_press_ms;
    if (key_count == '0) begin
      last_idx_in = '0;
    end else if (key_count > KEY_COUNT_W'(KEY_LIMIT)) begin
      last_idx_in = KEY_W'(KEY_LIMIT - 1);
    end else begin
      last_idx_in = KEY_W'(key_count - KEY_COUNT_W'(1));
    end
  end

  // Front stage: decide press or release for the key under the index.
  assign pressed    = !levels[idx];
  assign do_press   = (state == S_SCAN) && pressed && !key_down[idx];
  assign do_release = (state == S_SCAN) && !pressed && key_down[idx];

  // Each entry is read and written at most once per poll, so a read never
  // meets a write to the same entry in flight.
  mkslp_time_ram u_ram (
    .clk   (clk),
    .we    (do_press),
    .waddr (idx),
    .wdata (now),
    .re    (do_release),
    .raddr (idx),
    .rdata (rdata)
  );

  // Back stage: hold time from the memory read, then the two compares.
  assign hold     = now - rdata;
  assign is_long  = hold >= TIME_BITS'(long_thr);
  assign is_short = hold >= TIME_BITS'(MIN_PRESS_US);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  if (idx == last_idx) state_next = S_FLUSH;
      S_FLUSH: state_next = S_DONE;
      S_DONE:  if (batch_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      key_down <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= do_release;
      if (do_press) begin
        key_down[idx] <= 1'b1;
      end else if (do_release) begin
        key_down[idx] <= 1'b0;
      end
    end
  end

  // Poll payload, key index and report vectors.
  always_ff @(posedge clk) begin
    if (accept) begin
      levels   <= in_levels;
      now      <= in_now;
      long_thr <= LONG_THR_W'(lms) * LONG_THR_W'(US_PER_MS);
      last_idx <= last_idx_in;
      idx      <= '0;
      hit      <= '0;
      hit_long <= '0;
    end else begin
      if (state == S_SCAN) begin
        idx <= idx + KEY_W'(1);
      end
      if (s1_valid) begin
        hit[s1_idx]      <= is_long || is_short;
        hit_long[s1_idx] <= is_long;
      end
    end
    s1_idx <= idx;
  end

  assign batch.valid    = (state == S_DONE);
  assign batch.hit      = hit;
  assign batch.hit_long = hit_long;

endmodule

// File: design/mkslp_report.sv
// Report stage: holds the reports of one poll and sends them out in key
// order through an output register, marking the last. Depends on mkslp_pkg.
module mkslp_report
  import mkslp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rpt_batch_t       batch,
  output logic             batch_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] out_key,
  output logic             out_long,
  output logic             out_last
);

  logic [NUM_KEYS-1:0] pend_hit;
  logic [NUM_KEYS-1:0] pend_long;
  logic [KEY_W-1:0]    sel;
  logic [NUM_KEYS-1:0] sel_bit;
  logic                load_out;

  // A new poll is taken only once every report of the previous one has
  // moved into the output register.
  assign batch_ready = (pend_hit == '0);

  // Lowest pending key.
  always_comb begin
    sel = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend_hit[i]) sel = KEY_W'(i);
    end
    sel_bit = NUM_KEYS'(1) << sel;
  end

  assign load_out = (pend_hit != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_hit  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (batch.valid && batch_ready) begin
        pend_hit <= batch.hit;
      end else if (load_out) begin
        pend_hit <= pend_hit & ~sel_bit;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (batch.valid && batch_ready) begin
      pend_long <= batch.hit_long;
    end
    if (load_out) begin
      out_key  <= sel;
      out_long <= pend_long[sel];
      out_last <= (pend_hit & ~sel_bit) == '0;
    end
  end

endmodule

// File: design/multi_key_short_long_press.sv
// Top level of the multi-key short/long press detector: configuration
// registers, stream ports. Depends on mkslp_pkg, mkslp_scan, mkslp_report.
//
//  channel      | handshake                     | payload
//  -------------+-------------------------------+---------------------------------
//  poll in      | s_axis_tvalid / s_axis_tready | tdata: key_levels, now_us
//  report out   | m_axis_tvalid / m_axis_tready | tdata: key_index, is_long; tlast
//  config write | cfg_we                        | cfg_index, cfg_data
//
// A poll holds the scanner through the accept, a scan of the keys (key_count
// clamped to 1..8) one at a time through the press-time memory port, a flush
// for the last read to land and a handover of the reports to the report stage.
// Reports leave one per cycle from an output register when the receiver is ready,
// while the scanner takes the next poll.
// Reset (rst, synchronous) clears all key_down flags and restores 8 keys and
// 800 ms. A stalled output holds its item and, with reports behind it, blocks handover.
module multi_key_short_long_press
  import mkslp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,  // [7:0] key_levels, [55:8] now_us
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // [2:0] key_index, [3] is_long, zero above
  output logic                  m_axis_tlast,  // last_event
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [KEY_COUNT_W-1:0] key_count;
  logic [LONG_MS_W-1:0]   long_press_ms;
  rpt_batch_t             batch;
  logic                   batch_ready;
  logic [KEY_W-1:0]       out_key;
  logic                   out_long;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= KEY_COUNT_W'(8);
      long_press_ms <= LONG_MS_W'(DEFAULT_LONG_MS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_COUNT: key_count     <= cfg_data[KEY_COUNT_W-1:0];
        REG_LONG_MS:   long_press_ms <= cfg_data[LONG_MS_W-1:0];
        default: ;
      endcase
    end
  end

  mkslp_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_levels     (s_axis_tdata[LEVEL_BITS-1:0]),
    .in_now        (s_axis_tdata[LEVEL_BITS +: TIME_BITS]),
    .key_count     (key_count),
    .long_press_ms (long_press_ms),
    .batch         (batch),
    .batch_ready   (batch_ready)
  );

  mkslp_report u_report (
    .clk         (clk),
    .rst         (rst),
    .batch       (batch),
    .batch_ready (batch_ready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_key     (out_key),
    .out_long    (out_long),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_long, out_key};

endmodule

// File: bench/press_scoreboard_pkg.sv
// Scoreboard for the multi-key short/long press detector: a predictor of the
// release reports and the queue of reports still owed. Depends on mkslp_pkg.
package press_scoreboard_pkg;
  import mkslp_pkg::*;

  // One release report as the block should send it.
  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             is_long;
    logic             last_event;
  } press_report_t;

  class press_scoreboard;
    logic [KEY_COUNT_W-1:0] key_count;
    logic [LONG_MS_W-1:0]   long_ms;
    logic [NUM_KEYS-1:0]    key_down;
    logic [TIME_BITS-1:0]   press_time [NUM_KEYS];
    press_report_t          owed_reports [$];
    int                     errors;

    function new();
      key_count = 4'd8;
      long_ms   = 16'd800;
      key_down  = '0;
      errors    = 0;
    endfunction

    // Mirror a register write; both indexes of the port are real registers.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_KEY_COUNT) begin
        key_count = data[KEY_COUNT_W-1:0];
      end else if (idx == REG_LONG_MS) begin
        long_ms = data[LONG_MS_W-1:0];
      end
    endfunction

    // Scan one accepted poll and queue the reports it must cause.
    function void note_poll(logic [LEVEL_BITS-1:0] levels, logic [TIME_BITS-1:0] now);
      int                   active;
      int                   first_new;
      logic [TIME_BITS-1:0] long_thr;
      logic [TIME_BITS-1:0] hold;
      press_report_t        rpt;
      active = int'(key_count);
      if (active < 1) active = 1;
      if (active > KEY_LIMIT) active = KEY_LIMIT;
      // A zero threshold falls back to the default.
      long_thr = TIME_BITS'(((long_ms == 0) ? DEFAULT_LONG_MS : int'(long_ms)) * US_PER_MS);
      first_new = owed_reports.size();
      for (int i = 0; i < active; i++) begin
        if (!levels[i] && !key_down[i]) begin
          key_down[i]   = 1'b1;
          press_time[i] = now;
        end else if (levels[i] && key_down[i]) begin
          key_down[i] = 1'b0;
          // Hold time wraps with the timer.
          hold = now - press_time[i];
          rpt.key_index  = KEY_W'(i);
          rpt.last_event = 1'b0;
          if (hold >= long_thr) begin
            rpt.is_long = 1'b1;
            owed_reports.push_back(rpt);
          end else if (hold >= TIME_BITS'(MIN_PRESS_US)) begin
            rpt.is_long = 1'b0;
            owed_reports.push_back(rpt);
          end
        end
      end
      if (owed_reports.size() > first_new) owed_reports[$].last_event = 1'b1;
    endfunction

    function int pending();
      return owed_reports.size();
    endfunction

    // Compare one accepted report with the oldest one owed.
    function void check_report(logic [7:0] tdata, logic tlast);
      press_report_t want;
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none, got key %0d long %0b last %0b",
                 $time, tdata[KEY_W-1:0], tdata[KEY_W], tlast);
        return;
      end
      want = owed_reports.pop_front();
      if (tdata[KEY_W-1:0] !== want.key_index || tdata[KEY_W] !== want.is_long ||
          tlast !== want.last_event) begin
        errors++;
        $display({"%0t: report mismatch: expected key %0d long %0b last %0b, ",
                  "got key %0d long %0b last %0b"},
                 $time, want.key_index, want.is_long, want.last_event,
                 tdata[KEY_W-1:0], tdata[KEY_W], tlast);
      end
    endfunction
  endclass

endpackage

// File: bench/multi_key_short_long_press_test.sv
// Self-checking bench for multi_key_short_long_press: directed and random
// polls under several register settings, with random stalls on both streams.
// Depends on mkslp_pkg and press_scoreboard_pkg.
module multi_key_short_long_press_test;
  import mkslp_pkg::*;
  import press_scoreboard_pkg::*;

  localparam int DRAIN_CYCLES = 2 * (KEY_LIMIT + 3) + 4;
  localparam int RANDOM_POLLS = 66;
  localparam int STALL_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata = '0;  // [7:0] key_levels, [55:8] now_us
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;       // [2:0] key_index, [3] is_long
  logic                  m_axis_tlast;       // last_event
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  press_scoreboard       sb = new();
  logic [LEVEL_BITS-1:0] cur_levels = 8'hFF;
  logic [TIME_BITS-1:0]  cur_now = '0;
  bit                    calm = 1'b0;
  int                    polls_sent = 0;
  int                    reports_seen = 0;

  int phase_keys [6] = '{8, 3, 0, 15, 5, 8};
  int phase_ms   [6] = '{0, 50, 1, 65535, 200, 800};

  multi_key_short_long_press dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one poll after a random gap and wait until it is taken.
  task automatic send_poll(logic [LEVEL_BITS-1:0] levels, logic [TIME_BITS-1:0] now);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, levels};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_poll(levels, now);
    polls_sent++;
    cur_levels = levels;
    cur_now    = now;
  endtask

  // Random polls: mostly keys toggling a few at a time, with hold times
  // spread over bounce, short and long ranges, and the odd jump in time.
  task automatic run_random(int count, int long_thr_us);
    logic [31:0]          bits;
    logic [63:0]          wide;
    logic [LEVEL_BITS-1:0] levels;
    logic [TIME_BITS-1:0] now;
    int                   pick;
    for (int n = 0; n < count; n++) begin
      bits = $urandom & $urandom;
      levels = ($urandom_range(0, 99) < 85) ? (cur_levels ^ bits[7:0]) : 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        now = cur_now + TIME_BITS'($urandom_range(0, MIN_PRESS_US - 1));
      end else if (pick < 65) begin
        now = cur_now + TIME_BITS'($urandom_range(MIN_PRESS_US, 3 * MIN_PRESS_US));
      end else if (pick < 95) begin
        now = cur_now + TIME_BITS'($urandom_range(0, long_thr_us / 2));
      end else begin
        wide = {$urandom, $urandom};
        now  = wide[TIME_BITS-1:0];
      end
      send_poll(levels, now);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk) cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Stop offering polls and let every owed report and the scanner finish.
  task automatic wait_idle();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: a random wait before each item, and two long stalls while
  // the sender keeps going so that the block backs up into its input.
  initial begin
    int gap;
    int stalls_done;
    stalls_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stalls_done < 2 && polls_sent >= 100 + 200 * stalls_done) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stalls_done++;
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Check every accepted report.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_report(m_axis_tdata, m_axis_tlast);
      reports_seen++;
    end
  end

  initial begin
    int long_thr_us;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed polls at the reset settings: eight keys, 800 ms.
    send_poll(8'hFF, 48'd0);                 // nothing down, no report
    send_poll(8'h00, 48'd1000);              // all keys pressed
    send_poll(8'h01, 48'd30999);             // key 0 one below the minimum: bounce
    send_poll(8'h03, 48'd31000);             // key 1 exactly at the minimum: short
    send_poll(8'h03, 48'd400000);            // still held, press time not relatched
    send_poll(8'h07, 48'd800999);            // key 2 one below the long threshold
    send_poll(8'hFF, 48'd801000);            // keys 3 to 7 exactly long
    send_poll(8'h7F, 48'hFFFF_FFFF_D8F0);    // key 7 pressed just before the wrap
    send_poll(8'hFF, 48'd790000);            // long across the timer wrap
    send_poll(8'h00, 48'hFFFF_FFFF_FFFF);    // all pressed at the top time
    send_poll(8'hAA, 48'd29999);             // odd keys short across the wrap
    send_poll(8'hFF, 48'd799999);            // even keys long across the wrap
    send_poll(8'h00, 48'd900000);
    send_poll(8'hF0, 48'd920000);            // upper keys bounce
    send_poll(8'hFC, 48'd950000);            // keys 2 and 3 short
    send_poll(8'hFF, 48'd1700000);           // keys 0 and 1 long
    send_poll(8'hF0, 48'd2000000);
    send_poll(8'h00, 48'd2500000);
    send_poll(8'hFF, 48'd2800000);           // long and short reports in one poll
    run_random(RANDOM_POLLS, DEFAULT_LONG_MS * US_PER_MS);

    // Random polls under each further setting; the last runs without random gaps.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      calm = (p == 5);
      if (p == 4) cur_now = 48'hFFFF_FFE0_0000;
      write_reg(REG_KEY_COUNT, CFG_DATA_W'(phase_keys[p]));
      write_reg(REG_LONG_MS, CFG_DATA_W'(phase_ms[p]));
      long_thr_us = ((phase_ms[p] == 0) ? DEFAULT_LONG_MS : phase_ms[p]) * US_PER_MS;
      run_random(RANDOM_POLLS, long_thr_us);
    end
    wait_idle();

    $display("Sent %0d polls under 7 register settings and checked %0d release reports.",
             polls_sent, reports_seen);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("%0t: timeout with %0d reports still owed", $time, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
